FILE: hw/rtl/dbpt_pkg.sv
// types, constants and register codes shared by the pulse totalizer
`timescale 1ns / 1ps
package dbpt_pkg;

	localparam int INTEG_W    = 6;
	localparam int LPP_W      = 10;
	localparam int SUM_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DEBOUNCE_TOP_DEF = 56;

	localparam logic [LPP_W-1:0] LPP_RST  = LPP_W'(10);
	localparam logic [SUM_W-1:0] WRAP_RST = SUM_W'(100000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LITERS_PER_PULSE = 2'd0,
		CFG_WRAP_LIMIT       = 2'd1,
		CFG_HOT_PRESET       = 2'd2,
		CFG_COLD_PRESET      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic hot_level;
		logic cold_level;
	} in_t;

	typedef struct packed {
		logic [SUM_W-1:0] hot_total;
		logic [SUM_W-1:0] cold_total;
		logic             updated;
		logic             settling;
	} out_t;

	typedef struct packed {
		logic [INTEG_W-1:0] integ;
		logic               pulse;
	} integ_step_t;

endpackage

FILE: hw/rtl/dual_debounced_pulse_totalizer.sv
// top level of the dual debounced pulse totalizer
`timescale 1ns / 1ps
//
// channel  direction  handshake              payload
// in       request in in_valid / in_stall    in_data  (hot_level, cold_level)
// out      result out out_valid / out_stall  out_data (totals, updated, settling)
// cfg      write in   cfg_we                 cfg_index, cfg_data
//
// one poll request per cycle sustained while out_stall is low; input register s1,
// then result register s2; debounce counters and totals update as a request leaves s1
// reset clears counters to 1, totals to 0, config to defaults, seeding pending
// out_stall holds the result in s2; s1 still takes a request while s2 is free
// or drains in the same cycle, so in_stall rises only when both stages are full
//
module dual_debounced_pulse_totalizer
	import dbpt_pkg::*;
#(
	parameter int DEBOUNCE_TOP = DEBOUNCE_TOP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [INTEG_W-1:0] TOP_VAL = INTEG_W'(DEBOUNCE_TOP);
	localparam logic [INTEG_W-1:0] ONE_VAL = INTEG_W'(1);

	// one debounce counter step; seeding loads the rail that matches the pin
	function automatic integ_step_t integ_step(
		input logic [INTEG_W-1:0] integ,
		input logic               level,
		input logic               seed
	);
		integ_step_t r;
		r.integ = integ;
		r.pulse = 1'b0;
		if (seed) begin
			r.integ = level ? ONE_VAL : TOP_VAL;
		end else if (!level) begin
			if (integ < TOP_VAL) begin
				r.integ = integ + ONE_VAL;
				r.pulse = (r.integ == TOP_VAL);
			end else begin
				r.integ = TOP_VAL;
			end
		end else begin
			r.integ = (integ > ONE_VAL) ? integ - ONE_VAL : ONE_VAL;
		end
		return r;
	endfunction

	// add one pulse of volume at 33 bits, wrap once, keep 32 bits
	function automatic logic [SUM_W-1:0] sum_step(
		input logic [SUM_W-1:0] sum,
		input logic [LPP_W-1:0] lpp,
		input logic [SUM_W-1:0] wrap
	);
		logic [SUM_W:0] wide;
		wide = {1'b0, sum} + (SUM_W+1)'(lpp);
		if (wide >= {1'b0, wrap}) begin
			wide = wide - {1'b0, wrap};
		end
		return wide[SUM_W-1:0];
	endfunction

	// config registers
	logic [LPP_W-1:0] lpp_q;
	logic [SUM_W-1:0] wrap_q;

	// channel state
	logic [INTEG_W-1:0] hot_integ_q;
	logic [INTEG_W-1:0] cold_integ_q;
	logic [SUM_W-1:0]   hot_sum_q;
	logic [SUM_W-1:0]   cold_sum_q;
	logic               seeded_q;

	// pipeline
	logic valid_s1;
	in_t  data_s1;
	logic valid_s2;
	out_t data_s2;

	logic take_s1;
	logic adv_s2;

	integ_step_t      hot_step;
	integ_step_t      cold_step;
	logic [SUM_W-1:0] hot_sum_n;
	logic [SUM_W-1:0] cold_sum_n;
	logic             hot_settle;
	logic             cold_settle;
	out_t             result;

	// handshake: s2 frees when empty or draining, s1 moves whenever s2 can load
	assign adv_s2    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv_s2;
	assign take_s1   = in_valid && !in_stall;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	// single pass: counter step, sum update, flags
	always_comb begin
		hot_step    = integ_step(hot_integ_q, data_s1.hot_level, !seeded_q);
		cold_step   = integ_step(cold_integ_q, data_s1.cold_level, !seeded_q);
		hot_sum_n   = hot_step.pulse ? sum_step(hot_sum_q, lpp_q, wrap_q) : hot_sum_q;
		cold_sum_n  = cold_step.pulse ? sum_step(cold_sum_q, lpp_q, wrap_q) : cold_sum_q;
		hot_settle  = (hot_step.integ != ONE_VAL) && (hot_step.integ != TOP_VAL);
		cold_settle = (cold_step.integ != ONE_VAL) && (cold_step.integ != TOP_VAL);
		result.hot_total  = hot_sum_n;
		result.cold_total = cold_sum_n;
		result.updated    = hot_step.pulse || cold_step.pulse;
		result.settling   = hot_settle || cold_settle;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			data_s1 <= in_data;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			data_s2 <= result;
		end
	end

	// config registers; preset writes go straight into the totals below
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpp_q  <= LPP_RST;
			wrap_q <= WRAP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_LITERS_PER_PULSE: lpp_q  <= cfg_data[LPP_W-1:0];
				CFG_WRAP_LIMIT:       wrap_q <= cfg_data[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	// debounce counters and seeding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_integ_q  <= ONE_VAL;
			cold_integ_q <= ONE_VAL;
			seeded_q     <= 1'b0;
		end else if (adv_s2) begin
			hot_integ_q  <= hot_step.integ;
			cold_integ_q <= cold_step.integ;
			seeded_q     <= 1'b1;
		end
	end

	// totals; a preset write wins over a pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_sum_q  <= '0;
			cold_sum_q <= '0;
		end else begin
			if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_HOT_PRESET)) begin
				hot_sum_q <= cfg_data[SUM_W-1:0];
			end else if (adv_s2) begin
				hot_sum_q <= hot_sum_n;
			end
			if (cfg_we && (cfg_reg_t'(cfg_index) == CFG_COLD_PRESET)) begin
				cold_sum_q <= cfg_data[SUM_W-1:0];
			end else if (adv_s2) begin
				cold_sum_q <= cold_sum_n;
			end
		end
	end

`ifndef SYNTH
	// counters never leave the 1..top band
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(hot_integ_q >= ONE_VAL) && (hot_integ_q <= TOP_VAL) &&
		(cold_integ_q >= ONE_VAL) && (cold_integ_q <= TOP_VAL))
		else $error("debounce counter out of range");

	// a counted pulse leaves at least one counter at the top
	a_pulse_top: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && result.updated |=> (hot_integ_q == TOP_VAL) || (cold_integ_q == TOP_VAL))
		else $error("pulse counted without counter at top");

	// the first request after reset never counts a pulse
	a_seed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && !seeded_q |-> !result.updated)
		else $error("pulse counted on seeding request");

	// channel state moves only with a request or a write
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s2 && !cfg_we |=> $stable(hot_integ_q) && $stable(cold_integ_q) &&
		$stable(hot_sum_q) && $stable(cold_sum_q))
		else $error("channel state changed while idle");
`endif

endmodule

FILE: verif/dual_debounced_pulse_totalizer_test.sv
// self-checking testbench for the dual debounced pulse totalizer
`timescale 1ns / 1ps

module dual_debounced_pulse_totalizer_test;
	import dbpt_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POLLS = 116;
	localparam int DIRECTED_POLLS = 20;

	localparam logic [INTEG_W-1:0] TOP = INTEG_W'(DEBOUNCE_TOP_DEF);
	localparam logic [INTEG_W-1:0] ONE = INTEG_W'(1);

	// directed pin pattern, bit i is poll i; first poll seeds hot active, cold idle
	localparam logic [DIRECTED_POLLS-1:0] DIR_HOT  = 20'b11010110010001110010;
	localparam logic [DIRECTED_POLLS-1:0] DIR_COLD = 20'b10110011000111110011;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_t                   in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LITERS_PER_PULSE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// polls waiting to be sent and readings waiting to come back
	in_t  poll_q [$];
	out_t expected_readings [$];

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// shadow of the meter: channel 0 is hot, channel 1 is cold
	logic [INTEG_W-1:0] integ_lvl [2];
	logic [SUM_W-1:0]   totals [2];
	logic [LPP_W-1:0]   lpp_cfg = LPP_RST;
	logic [SUM_W-1:0]   wrap_cfg = WRAP_RST;
	logic               seeded = 1'b0;

	initial begin
		integ_lvl[0] = ONE;
		integ_lvl[1] = ONE;
		totals[0] = '0;
		totals[1] = '0;
	end

	dual_debounced_pulse_totalizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// one channel, one poll: integrate toward top or floor, count on reaching top
	function automatic logic debounce_step(int ch, logic level);
		logic [SUM_W:0] acc;
		logic           pulse;
		pulse = 1'b0;
		if (!level) begin
			if (integ_lvl[ch] < TOP) begin
				integ_lvl[ch] = integ_lvl[ch] + ONE;
				pulse = (integ_lvl[ch] == TOP);
			end
		end else if (integ_lvl[ch] > ONE) begin
			integ_lvl[ch] = integ_lvl[ch] - ONE;
		end
		if (pulse) begin
			// 33-bit add, one conditional wrap, then keep the low word
			acc = {1'b0, totals[ch]} + {{(SUM_W + 1 - LPP_W){1'b0}}, lpp_cfg};
			if (acc >= {1'b0, wrap_cfg})
				acc = acc - {1'b0, wrap_cfg};
			totals[ch] = acc[SUM_W-1:0];
		end
		return pulse;
	endfunction

	// full meter update for one poll request, returns the expected reading
	function automatic out_t meter_poll(in_t req);
		out_t r;
		logic hot_pulse;
		logic cold_pulse;
		hot_pulse = 1'b0;
		cold_pulse = 1'b0;
		if (!seeded) begin
			// first poll after reset only places the counters
			integ_lvl[0] = req.hot_level ? ONE : TOP;
			integ_lvl[1] = req.cold_level ? ONE : TOP;
			seeded = 1'b1;
		end else begin
			hot_pulse = debounce_step(0, req.hot_level);
			cold_pulse = debounce_step(1, req.cold_level);
		end
		r.hot_total = totals[0];
		r.cold_total = totals[1];
		r.updated = hot_pulse | cold_pulse;
		r.settling = (integ_lvl[0] != ONE && integ_lvl[0] != TOP) ||
			(integ_lvl[1] != ONE && integ_lvl[1] != TOP);
		return r;
	endfunction

	// register write, only issued while nothing is in flight
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LITERS_PER_PULSE: lpp_cfg = val[LPP_W-1:0];
			CFG_WRAP_LIMIT:       wrap_cfg = val;
			CFG_HOT_PRESET:       totals[0] = val;
			CFG_COLD_PRESET:      totals[1] = val;
			default:              ;
		endcase
	endtask

	// sender holds off until every reading is back, then lets the pipe settle
	task automatic drain();
		while (poll_q.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// request driver: predicts on acceptance, holds a stalled request steady
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_readings.push_back(meter_poll(in_data));
				void'(poll_q.pop_front());
			end
			// free to change valid only when nothing is waiting on the port
			if (!in_valid || !in_stall) begin
				if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= poll_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// reading monitor: compares each accepted reading with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reading: hot %0d cold %0d upd %b settle %b",
							out_data.hot_total, out_data.cold_total,
							out_data.updated, out_data.settling);
				end else begin
					want = expected_readings.pop_front();
					if (out_data.hot_total !== want.hot_total ||
						out_data.cold_total !== want.cold_total ||
						out_data.updated !== want.updated ||
						out_data.settling !== want.settling) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("reading mismatch: expected hot %0d cold %0d upd %b settle %b",
								want.hot_total, want.cold_total, want.updated,
								want.settling);
							$display("  got hot %0d cold %0d upd %b settle %b",
								out_data.hot_total, out_data.cold_total,
								out_data.updated, out_data.settling);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int unsigned run_left [2];
		logic        lvl [2];
		in_t         req;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hot total just below the default wrap so the directed pulses wrap it
		write_reg(CFG_HOT_PRESET, 32'd99999995);
		write_reg(CFG_COLD_PRESET, $urandom);

		// directed: seeding, quick pulse from a seeded-active pin, floor and top hold
		@(negedge clk);
		for (int i = 0; i < DIRECTED_POLLS; i++) begin
			req.hot_level = DIR_HOT[i];
			req.cold_level = DIR_COLD[i];
			poll_q.push_back(req);
		end
		drain();

		for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
			case (phase)
				1: begin
					// largest wrap limit, totals about to cross it
					write_reg(CFG_LITERS_PER_PULSE, 32'd1);
					write_reg(CFG_WRAP_LIMIT, 32'hFFFF_FFFF);
					write_reg(CFG_HOT_PRESET, 32'hFFFF_FFF0);
					write_reg(CFG_COLD_PRESET, 32'hFFFF_FFFE);
				end
				2: begin
					// zero wrap limit, sums running past 32 bits
					write_reg(CFG_LITERS_PER_PULSE, 32'd1023);
					write_reg(CFG_WRAP_LIMIT, 32'd0);
					write_reg(CFG_HOT_PRESET, 32'hFFFF_FFFF);
					write_reg(CFG_COLD_PRESET, $urandom);
				end
				3: begin
					// zero volume per pulse still flags an update
					write_reg(CFG_LITERS_PER_PULSE, 32'd0);
					write_reg(CFG_WRAP_LIMIT, $urandom);
					write_reg(CFG_HOT_PRESET, $urandom);
					write_reg(CFG_COLD_PRESET, $urandom);
				end
				4: begin
					write_reg(CFG_LITERS_PER_PULSE, 32'd1000);
					write_reg(CFG_WRAP_LIMIT, 32'd1);
					write_reg(CFG_HOT_PRESET, 32'd0);
					write_reg(CFG_COLD_PRESET, 32'd0);
				end
				5: begin
					// small wrap so totals wrap often
					write_reg(CFG_LITERS_PER_PULSE, $urandom_range(1023));
					write_reg(CFG_WRAP_LIMIT, $urandom_range(5000, 1));
					write_reg(CFG_HOT_PRESET, $urandom_range(4999));
					write_reg(CFG_COLD_PRESET, $urandom_range(4999));
				end
				6: begin
					write_reg(CFG_LITERS_PER_PULSE, 32'(LPP_RST));
					write_reg(CFG_WRAP_LIMIT, WRAP_RST);
					write_reg(CFG_HOT_PRESET, 32'd0);
					write_reg(CFG_COLD_PRESET, 32'd0);
				end
				7: begin
					write_reg(CFG_LITERS_PER_PULSE, $urandom_range(1000, 1));
					write_reg(CFG_WRAP_LIMIT, $urandom);
					write_reg(CFG_HOT_PRESET, $urandom);
					write_reg(CFG_COLD_PRESET, $urandom);
				end
				default: begin
					// presets may sit above the wrap limit here
					write_reg(CFG_LITERS_PER_PULSE, $urandom_range(1023));
					write_reg(CFG_WRAP_LIMIT, $urandom_range(20000));
					write_reg(CFG_HOT_PRESET, $urandom);
					write_reg(CFG_COLD_PRESET, $urandom);
				end
			endcase

			@(negedge clk);
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 72;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 72;
				end
				default: begin
					send_idle_pct = 26;
					stall_pct = 26;
				end
			endcase

			// pin runs: long active runs reach the top and count a pulse,
			// short runs and single flipped polls act as contact bounce
			run_left[0] = 0;
			run_left[1] = 0;
			lvl[0] = 1'($urandom_range(1));
			lvl[1] = 1'($urandom_range(1));
			for (int n = 0; n < PHASE_POLLS; n++) begin
				for (int ch = 0; ch < 2; ch++) begin
					if (run_left[ch] == 0) begin
						lvl[ch] = ~lvl[ch];
						if ($urandom_range(9) < 2)
							run_left[ch] = $urandom_range(4, 1);
						else if (!lvl[ch])
							run_left[ch] = $urandom_range(70, 50);
						else
							run_left[ch] = $urandom_range(60, 1);
					end
					run_left[ch]--;
				end
				req.hot_level = ($urandom_range(19) == 0) ? ~lvl[0] : lvl[0];
				req.cold_level = ($urandom_range(19) == 0) ? ~lvl[1] : lvl[1];
				poll_q.push_back(req);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
